[design/safs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_pkg
// Shared types and constants for the sorted address floor search block.
// ----------------------------------------------------------------------------
package safs_pkg;

  localparam int ADDR_W      = 64;
  localparam int OUT_INDEX_W = 10;
  localparam int IN_INDEX_W  = 10;
  localparam int COUNT_W     = 11;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINAL,
    S_DONE
  } search_state_t;

  typedef struct packed {
    logic                   status;
    logic [OUT_INDEX_W-1:0] found_index;
    logic                   exact_match;
  } result_t;

endpackage

[design/sorted_address_floor_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_address_floor_search
// Sorted address table with a floor lookup by binary search.
// ----------------------------------------------------------------------------
// Writes are accepted back to back. A lookup runs up to clog2(n+1) probes,
// one table read each, then the closest-below check where the search ends
// between entries, and moves its result into the output register. Input
// stays stalled until then, which can wait on out_stall.
// Synchronous reset clears the control state and entry_count; table
// contents are undefined until written.
module sorted_address_floor_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [safs_pkg::IN_INDEX_W-1:0]  entry_index,
  input  logic [safs_pkg::ADDR_W-1:0]      entry_address,
  input  logic [safs_pkg::ADDR_W-1:0]      lookup_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             status,
  output logic [safs_pkg::OUT_INDEX_W-1:0] found_index,
  output logic                             exact_match,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [safs_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [safs_pkg::COUNT_W-1:0] entry_count;
  logic [CW-1:0]                count;
  logic                         res_ready, res_valid;
  safs_pkg::result_t            res;

  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [safs_pkg::ADDR_W-1:0]  mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // Saturate the count at the table depth
  assign count = (32'(entry_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entry_count);

  // Output register: free when empty or being taken this cycle
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status      <= res.status;
      found_index <= res.found_index;
      exact_match <= res.exact_match;
    end
  end

  safs_search #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_search (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .entry_index    (entry_index),
    .entry_address  (entry_address),
    .lookup_address (lookup_address),
    .count          (count),
    .res_ready      (res_ready),
    .res_valid      (res_valid),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  safs_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[design/safs_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_table
// Address table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module safs_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [safs_pkg::ADDR_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [safs_pkg::ADDR_W-1:0] rdata
);

  logic [safs_pkg::ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/safs_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_search
// Request sequencer: takes write and lookup transactions, drives the table
// ports and runs the binary search one probe per cycle.
// ----------------------------------------------------------------------------
module safs_search #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int CW    = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [safs_pkg::IN_INDEX_W-1:0]  entry_index,
  input  logic [safs_pkg::ADDR_W-1:0]      entry_address,
  input  logic [safs_pkg::ADDR_W-1:0]      lookup_address,
  input  logic [CW-1:0]                    count,
  input  logic                             res_ready,
  output logic                             res_valid,
  output safs_pkg::result_t                res,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic [safs_pkg::ADDR_W-1:0]      mem_wdata,
  output logic                             mem_re,
  output logic [AW-1:0]                    mem_raddr,
  input  logic [safs_pkg::ADDR_W-1:0]      mem_rdata
);

  safs_pkg::search_state_t state, state_next;

  logic [safs_pkg::ADDR_W-1:0] key;
  logic [CW-1:0]               lo, hi, mid;

  logic          accept, lookup_go;
  logic          key_lt, key_gt, hit;
  logic [CW-1:0] lo_c, hi_c, mid_c, hi_dec;
  logic [CW:0]   sum_c;
  logic          go_probe, go_final, launch;

  assign accept    = in_valid && !in_stall;
  assign lookup_go = accept && (req_type == safs_pkg::REQ_LOOKUP);

  assign key_lt = key < mem_rdata;
  assign key_gt = key > mem_rdata;
  assign hit    = (state == safs_pkg::S_PROBE) && !key_lt && !key_gt;

  // Load the search window on a new lookup, else narrow it from the current probe result
  always_comb begin
    lo_c = lo;
    hi_c = hi;
    if (state == safs_pkg::S_IDLE) begin
      lo_c = '0;
      hi_c = count;
    end else if (key_lt) begin
      hi_c = mid;
    end else if (key_gt) begin
      lo_c = mid + CW'(1);
    end
  end

  assign sum_c    = {1'b0, lo_c} + {1'b0, hi_c};
  assign mid_c    = sum_c[CW:1];
  assign hi_dec   = hi_c - CW'(1);
  assign go_probe = lo_c < hi_c;
  assign go_final = !go_probe && (hi_c != '0) && (hi_c < count);
  assign launch   = lookup_go || ((state == safs_pkg::S_PROBE) && !hit);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      safs_pkg::S_IDLE: begin
        if (lookup_go) begin
          state_next = go_probe ? safs_pkg::S_PROBE :
                       go_final ? safs_pkg::S_FINAL : safs_pkg::S_DONE;
        end
      end
      safs_pkg::S_PROBE: begin
        if (hit) begin
          state_next = safs_pkg::S_DONE;
        end else begin
          state_next = go_probe ? safs_pkg::S_PROBE :
                       go_final ? safs_pkg::S_FINAL : safs_pkg::S_DONE;
        end
      end
      safs_pkg::S_FINAL: state_next = safs_pkg::S_DONE;
      safs_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = safs_pkg::S_IDLE;
        end
      end
      default: state_next = safs_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall  = (state != safs_pkg::S_IDLE);
    res_valid = (state == safs_pkg::S_DONE);
    mem_we    = accept && (req_type == safs_pkg::REQ_WRITE) &&
                (32'(entry_index) < DEPTH);
    mem_waddr = AW'(entry_index);
    mem_wdata = entry_address;
    mem_re    = launch;
    mem_raddr = go_probe ? mid_c[AW-1:0] : hi_dec[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= safs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_go) begin
      key <= lookup_address;
    end
    if (launch) begin
      lo  <= lo_c;
      hi  <= hi_c;
      mid <= mid_c;
    end
  end

  // Capture the result as the search resolves
  always_ff @(posedge clk) begin
    if (hit) begin
      res.status      <= safs_pkg::STATUS_FOUND;
      res.found_index <= safs_pkg::OUT_INDEX_W'(mid);
      res.exact_match <= 1'b1;
    end else if (state == safs_pkg::S_FINAL && key_gt) begin
      res.status      <= safs_pkg::STATUS_FOUND;
      res.found_index <= safs_pkg::OUT_INDEX_W'(hi - CW'(1));
      res.exact_match <= 1'b0;
    end else if (state == safs_pkg::S_FINAL || (launch && !go_probe && !go_final)) begin
      res.status      <= safs_pkg::STATUS_RANGE;
      res.found_index <= '0;
      res.exact_match <= 1'b0;
    end
  end

endmodule

[design/safs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_checker
// Port-level checks for the sorted address floor search block.
// ----------------------------------------------------------------------------
module safs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             req_type,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             status,
  input logic [safs_pkg::OUT_INDEX_W-1:0] found_index,
  input logic                             exact_match
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(found_index) && $stable(exact_match))
    else $error("stalled result changed");

  // An out-of-range result carries zero index and no match
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == safs_pkg::STATUS_RANGE) |->
      (found_index == '0) && !exact_match)
    else $error("out-of-range result with nonzero fields");

  // A lookup keeps the input side busy on the next cycle
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == safs_pkg::REQ_LOOKUP) |=> in_stall)
    else $error("input taken during a search");

  // A table write leaves the input side free
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == safs_pkg::REQ_WRITE) |=> !in_stall)
    else $error("input stalled after a write");

endmodule

bind sorted_address_floor_search safs_checker u_safs_checker (.*);

[tb/sorted_address_floor_search_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_address_floor_search_test
// Drives table writes and floor lookups into the search block and compares
// each lookup result against a hand-checked value or an in-bench floor
// search over a mirrored table. A short table of directed cases, most of
// them hand-checked, runs first. Random phases follow: they load small sorted
// or unsorted tables under changing back-pressure on both channels, then one
// full table with no back-pressure and a set of entry_count settings up to the saturating values.
// ----------------------------------------------------------------------------
module sorted_address_floor_search_test;

  localparam int DEPTH         = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 500_000;

  localparam logic [safs_pkg::ADDR_W-1:0] ADDR_MAX = '1;
  localparam safs_pkg::result_t OUT_OF_RANGE = '{safs_pkg::STATUS_RANGE, '0, 1'b0};

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WRITE,
    ROW_LOOKUP
  } row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [safs_pkg::IN_INDEX_W-1:0] idx;
    logic [safs_pkg::ADDR_W-1:0]     value;
    bit                              typed;
    safs_pkg::result_t               want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             in_valid       = 1'b0;
  logic                             in_stall;
  logic                             req_type       = safs_pkg::REQ_WRITE;
  logic [safs_pkg::IN_INDEX_W-1:0]  entry_index    = '0;
  logic [safs_pkg::ADDR_W-1:0]      entry_address  = '0;
  logic [safs_pkg::ADDR_W-1:0]      lookup_address = '0;
  logic                             out_valid;
  logic                             out_stall      = 1'b0;
  logic                             status;
  logic [safs_pkg::OUT_INDEX_W-1:0] found_index;
  logic                             exact_match;
  logic                             cfg_valid      = 1'b0;
  logic                             cfg_ready;
  logic [safs_pkg::COUNT_W-1:0]     cfg_data       = '0;

  logic [safs_pkg::ADDR_W-1:0]  shadow_table [DEPTH];
  logic [safs_pkg::COUNT_W-1:0] shadow_count = '0;
  safs_pkg::result_t            pending_results [$];
  dir_row_t                     directed_rows [$];
  int unsigned                  wide_counts [$];

  int unsigned items_sent     = 0;
  int unsigned errors         = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  sorted_address_floor_search #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .entry_index   (entry_index),
    .entry_address (entry_address),
    .lookup_address(lookup_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .found_index   (found_index),
    .exact_match   (exact_match),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [safs_pkg::ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Binary search with midpoint (low+high)/2; the end marker only on an exact hit.
  function automatic safs_pkg::result_t predict_floor(logic [safs_pkg::ADDR_W-1:0] key);
    int unsigned       n, lo, hi, mid;
    safs_pkg::result_t r;
    n  = (shadow_count > DEPTH) ? DEPTH : shadow_count;
    lo = 0;
    hi = n;
    r  = OUT_OF_RANGE;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key < shadow_table[mid]) begin
        hi = mid;
      end else if (key > shadow_table[mid]) begin
        lo = mid + 1;
      end else begin
        r = '{safs_pkg::STATUS_FOUND, mid[safs_pkg::OUT_INDEX_W-1:0], 1'b1};
        return r;
      end
    end
    if (hi > 0 && hi < n && key > shadow_table[hi-1]) begin
      mid = hi - 1;
      r   = '{safs_pkg::STATUS_FOUND, mid[safs_pkg::OUT_INDEX_W-1:0], 1'b0};
    end
    return r;
  endfunction

  // Favor stored addresses and their neighbors so hits and floors both occur.
  function automatic logic [safs_pkg::ADDR_W-1:0] pick_key(int unsigned n);
    int unsigned                 i;
    logic [safs_pkg::ADDR_W-1:0] k;
    k = rand64();
    if (n == 0) begin
      if ($urandom_range(0, 2) == 0) k = $urandom_range(0, 1) ? ADDR_MAX : '0;
      return k;
    end
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: k = shadow_table[i];
      3:       k = shadow_table[n-1];
      4:       k = shadow_table[i] + 1;
      5:       k = shadow_table[i] - 1;
      6:       k = shadow_table[n-1] + 1;
      7:       k = $urandom_range(0, 1) ? ADDR_MAX : '0;
      default: ;
    endcase
    return k;
  endfunction

  task automatic send_item(input logic req, input logic [safs_pkg::IN_INDEX_W-1:0] idx,
                           input logic [safs_pkg::ADDR_W-1:0] waddr,
                           input logic [safs_pkg::ADDR_W-1:0] key,
                           input bit typed, input safs_pkg::result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= req;
    entry_index    <= idx;
    entry_address  <= waddr;
    lookup_address <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req == safs_pkg::REQ_WRITE) begin
      shadow_table[idx] = waddr;
    end else begin
      pending_results.push_back(typed ? want : predict_floor(key));
    end
    items_sent++;
  endtask

  task automatic send_write(input int unsigned idx, input logic [safs_pkg::ADDR_W-1:0] addr);
    send_item(safs_pkg::REQ_WRITE, idx[safs_pkg::IN_INDEX_W-1:0], addr, rand64(), 1'b0,
              OUT_OF_RANGE);
  endtask

  task automatic send_lookup(input logic [safs_pkg::ADDR_W-1:0] key);
    send_item(safs_pkg::REQ_LOOKUP, safs_pkg::IN_INDEX_W'($urandom_range(0, DEPTH - 1)),
              rand64(), key, 1'b0, OUT_OF_RANGE);
  endtask

  // Hold off input until every lookup has answered, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int unsigned count);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= count[safs_pkg::COUNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    shadow_count  = count[safs_pkg::COUNT_W-1:0];
  endtask

  // Fill entries 0..n-1, sorted with random gaps and the odd duplicate,
  // or unsorted now and then.
  task automatic load_table(input int unsigned n);
    int unsigned                 i;
    logic [safs_pkg::ADDR_W-1:0] span, val;
    bit                          unsorted;
    if (n == 0) return;
    unsorted = ($urandom_range(0, 4) == 0);
    span     = ADDR_MAX / (n + 1);
    val      = ($urandom_range(0, 3) == 0) ? '0 : rand64() % span;
    for (i = 0; i < n; i++) begin
      if (unsorted) begin
        val = rand64();
      end else if (i > 0 && $urandom_range(0, 7) != 0) begin
        val = val + 1 + rand64() % span;
      end
      if (!unsorted && i == n - 1 && $urandom_range(0, 3) == 0) val = ADDR_MAX;
      send_write(i, val);
    end
  endtask

  task automatic run_small_phase();
    int unsigned n, lookups, j;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
    write_count(n);
    load_table(n);
    lookups = $urandom_range(15, 35);
    for (j = 0; j < lookups; j++) begin
      if ($urandom_range(0, 11) == 0) send_write($urandom_range(0, DEPTH - 1), rand64());
      else send_lookup(pick_key(n));
    end
  endtask

  always @(posedge clk) begin : check_results
    safs_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no lookup outstanding: status=%0d index=%0d exact=%0d",
                 $time, status, found_index, exact_match);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (found_index !== want.found_index) begin
          $display("%0t: found_index expected %0d actual %0d",
                   $time, want.found_index, found_index);
          errors++;
        end
        if (exact_match !== want.exact_match) begin
          $display("%0t: exact_match expected %0d actual %0d",
                   $time, want.exact_match, exact_match);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned k, j, n;
    directed_rows = '{
      '{ROW_CFG,    10'd0,    64'd0,        1'b0, OUT_OF_RANGE},
      '{ROW_LOOKUP, 10'd0,    64'd0,        1'b1, OUT_OF_RANGE},
      '{ROW_LOOKUP, 10'd0,    ADDR_MAX,     1'b1, OUT_OF_RANGE},
      '{ROW_WRITE,  10'd0,    64'd0,        1'b0, OUT_OF_RANGE},
      '{ROW_WRITE,  10'd1,    64'd100,      1'b0, OUT_OF_RANGE},
      '{ROW_WRITE,  10'd2,    64'd300,      1'b0, OUT_OF_RANGE},
      '{ROW_WRITE,  10'd3,    64'd1000,     1'b0, OUT_OF_RANGE},
      '{ROW_WRITE,  10'd1023, ADDR_MAX,     1'b0, OUT_OF_RANGE},
      '{ROW_CFG,    10'd0,    64'd4,        1'b0, OUT_OF_RANGE},
      '{ROW_LOOKUP, 10'd0,    64'd0,        1'b1, '{safs_pkg::STATUS_FOUND, 10'd0, 1'b1}},
      '{ROW_LOOKUP, 10'd0,    64'd150,      1'b1, '{safs_pkg::STATUS_FOUND, 10'd1, 1'b0}},
      '{ROW_LOOKUP, 10'd0,    64'd2000,     1'b1, OUT_OF_RANGE},
      '{ROW_LOOKUP, 10'd0,    64'd1000,     1'b1, '{safs_pkg::STATUS_FOUND, 10'd3, 1'b1}},
      '{ROW_LOOKUP, 10'd0,    ADDR_MAX,     1'b1, OUT_OF_RANGE},
      '{ROW_WRITE,  10'd3,    ADDR_MAX,     1'b0, OUT_OF_RANGE},
      '{ROW_LOOKUP, 10'd0,    ADDR_MAX,     1'b1, '{safs_pkg::STATUS_FOUND, 10'd3, 1'b1}},
      '{ROW_LOOKUP, 10'd0,    ADDR_MAX - 1, 1'b1, '{safs_pkg::STATUS_FOUND, 10'd2, 1'b0}},
      '{ROW_CFG,    10'd0,    64'd1,        1'b0, OUT_OF_RANGE},
      '{ROW_LOOKUP, 10'd0,    64'd0,        1'b1, '{safs_pkg::STATUS_FOUND, 10'd0, 1'b1}},
      '{ROW_LOOKUP, 10'd0,    64'd5,        1'b1, OUT_OF_RANGE},
      '{ROW_WRITE,  10'd1,    64'd5000,     1'b0, OUT_OF_RANGE},
      '{ROW_CFG,    10'd0,    64'd4,        1'b0, OUT_OF_RANGE},
      '{ROW_LOOKUP, 10'd0,    64'd200,      1'b0, OUT_OF_RANGE},
      '{ROW_LOOKUP, 10'd0,    64'd4000,     1'b0, OUT_OF_RANGE},
      '{ROW_LOOKUP, 10'd0,    64'd5000,     1'b0, OUT_OF_RANGE},
      '{ROW_CFG,    10'd0,    64'd2,        1'b0, OUT_OF_RANGE},
      '{ROW_LOOKUP, 10'd0,    64'd6000,     1'b0, OUT_OF_RANGE}
    };
    wide_counts = '{2047, 1024, 1025, 1023, 1536};
    wide_counts.push_back($urandom_range(1, DEPTH - 2));

    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 38;
    recv_stall_pct = 83;
    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_CFG:   write_count(32'(directed_rows[r].value[safs_pkg::COUNT_W-1:0]));
        ROW_WRITE: send_write(32'(directed_rows[r].idx), directed_rows[r].value);
        default:   send_item(safs_pkg::REQ_LOOKUP,
                             safs_pkg::IN_INDEX_W'($urandom_range(0, DEPTH - 1)), rand64(),
                             directed_rows[r].value, directed_rows[r].typed,
                             directed_rows[r].want);
      endcase
    end
    while (items_sent < 220) run_small_phase();

    send_idle_pct  = 83;
    recv_stall_pct = 38;
    while (items_sent < 400) run_small_phase();

    // Full table: the only place the count saturates and the top indexes appear.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_table(DEPTH);
    for (k = 0; k < wide_counts.size(); k++) begin
      write_count(wide_counts[k]);
      n = (wide_counts[k] > DEPTH) ? DEPTH : wide_counts[k];
      for (j = 0; j < 30; j++) begin
        if (k == 0 && j == 15) drain_results();
        send_lookup(pick_key(n));
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
